// ----- rtl/core/tzs_pkg.sv -----
// Shared types and constants for the UTC+8 time-zone shift block.
// Depends on nothing; every other file in rtl/core refers to it by scoped names.
`default_nettype none

package tzs_pkg;

  // Calendar and offset constants
  localparam int unsigned YearBase       = 2000;
  localparam int unsigned MinPerDay      = 24 * 60;
  localparam int unsigned MinPerHour     = 60;
  localparam int unsigned QuarterMin     = 15;
  localparam int unsigned TargetMin      = 8 * 60;
  // Only century year in the reachable year span that is not a leap year
  // (the 400-year rule makes 2000 a leap year).
  localparam int unsigned CenturyNonLeap = 2100;

  // Divide by 60 as multiply by reciprocal, exact for values below 1440
  localparam int unsigned RecipSixty     = 2185;
  localparam int unsigned RecipShift     = 17;

  typedef struct packed {
    logic [6:0] year_two_digit;
    logic [3:0] month_in;
    logic [4:0] day_in;
    logic [4:0] hour_in;
    logic [5:0] minute_in;
    logic [5:0] second_in;
    logic       tz_negative;
    logic [6:0] tz_quarters;
  } tz_req_t;

  typedef struct packed {
    logic [11:0] year_out;
    logic [3:0]  month_out;
    logic [4:0]  day_out;
    logic [4:0]  hour_out;
    logic [5:0]  minute_out;
    logic [5:0]  second_out;
  } tz_res_t;

endpackage

`default_nettype wire

// ----- rtl/core/tzs_convert.sv -----
// Combinational date/time conversion from local time to UTC+8.
// Depends on tzs_pkg for the request/result structs and constants.
`default_nettype none

module tzs_convert (
  input  wire tzs_pkg::tz_req_t req_i,
  output tzs_pkg::tz_res_t      res_o
);

  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
  } date_t;

  localparam logic signed [12:0] DayS    = 13'(tzs_pkg::MinPerDay);
  localparam logic signed [12:0] TwoDayS = 13'(2 * tzs_pkg::MinPerDay);

  // Gregorian rule narrowed to the reachable year span
  function automatic logic [4:0] month_days(logic [11:0] y, logic [3:0] m);
    logic leap;
    leap = (y[1:0] == 2'b00) && (y != 12'(tzs_pkg::CenturyNonLeap));
    case (m)
      4'd2:                      month_days = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:   month_days = 5'd30;
      default:                   month_days = 5'd31;
    endcase
  endfunction

  // Advance or retreat the date by one day
  function automatic date_t day_step(date_t d, logic fwd);
    date_t r;
    r = d;
    if (fwd) begin
      if (({1'b0, d.day} + 6'd1) > {1'b0, month_days(d.year, d.month)}) begin
        r.day = 5'd1;
        if (d.month >= 4'd12) begin
          r.month = 4'd1;
          r.year  = d.year + 12'd1;
        end else begin
          r.month = d.month + 4'd1;
        end
      end else begin
        r.day = d.day + 5'd1;
      end
    end else begin
      if (d.day <= 5'd1) begin
        if (d.month <= 4'd1) begin
          r.month = 4'd12;
          r.year  = d.year - 12'd1;
        end else begin
          r.month = d.month - 4'd1;
        end
        r.day = month_days(r.year, r.month);
      end else begin
        r.day = d.day - 5'd1;
      end
    end
    return r;
  endfunction

  logic [10:0]        hm;
  logic [10:0]        tz_min;
  logic signed [12:0] total1;
  logic signed [12:0] time1_s;
  logic [10:0]        time1;
  logic               step_en_a, step_en_b, step_fwd;
  logic [11:0]        total2;
  logic               day2;
  logic [10:0]        time2;
  logic [22:0]        prod;
  logic [4:0]         hour;
  date_t              d0, d1, d2, d3;

  always_comb begin
    hm     = 11'(req_i.hour_in) * 11'(tzs_pkg::MinPerHour) + 11'(req_i.minute_in);
    tz_min = 11'(req_i.tz_quarters) * 11'(tzs_pkg::QuarterMin);
    // Subtracting a negative offset adds its magnitude
    if (req_i.tz_negative) begin
      total1 = $signed({2'b00, hm}) + $signed({2'b00, tz_min});
    end else begin
      total1 = $signed({2'b00, hm}) - $signed({2'b00, tz_min});
    end

    // Floor division by a day; the shift is bounded to two days either way
    step_en_a = 1'b1;
    step_en_b = 1'b0;
    step_fwd  = 1'b0;
    if (total1 < -DayS) begin
      step_en_b = 1'b1;
      time1_s   = total1 + TwoDayS;
    end else if (total1 < 13'sd0) begin
      time1_s   = total1 + DayS;
    end else if (total1 < DayS) begin
      step_en_a = 1'b0;
      time1_s   = total1;
    end else if (total1 < TwoDayS) begin
      step_fwd  = 1'b1;
      time1_s   = total1 - DayS;
    end else begin
      step_fwd  = 1'b1;
      step_en_b = 1'b1;
      time1_s   = total1 - TwoDayS;
    end
    time1 = time1_s[10:0];

    total2 = {1'b0, time1} + 12'(tzs_pkg::TargetMin);
    day2   = total2 >= 12'(tzs_pkg::MinPerDay);
    time2  = day2 ? 11'(total2 - 12'(tzs_pkg::MinPerDay)) : total2[10:0];

    prod = 23'(time2) * 23'(tzs_pkg::RecipSixty);
    hour = 5'(prod >> tzs_pkg::RecipShift);

    d0.year  = 12'(req_i.year_two_digit) + 12'(tzs_pkg::YearBase);
    d0.month = req_i.month_in;
    d0.day   = req_i.day_in;
    // Order matters for out-of-range days: the UTC shift first, then +8 h
    d1 = step_en_a ? day_step(d0, step_fwd) : d0;
    d2 = step_en_b ? day_step(d1, step_fwd) : d1;
    d3 = day2 ? day_step(d2, 1'b1) : d2;

    res_o.year_out   = d3.year;
    res_o.month_out  = d3.month;
    res_o.day_out    = d3.day;
    res_o.hour_out   = hour;
    res_o.minute_out = 6'(time2 - 11'(hour) * 11'(tzs_pkg::MinPerHour));
    res_o.second_out = req_i.second_in;
  end

endmodule

`default_nettype wire

// ----- rtl/core/timezone_shift_to_utc_plus8.sv -----
// Top level of the UTC+8 time-zone shift block: input and result registers.
// Depends on tzs_pkg and tzs_convert.
//
// Usage:
//   A request on the input channel (in_valid_i / in_ready_o / in_req_i)
//   carries a local date and time plus a zone offset in quarter hours.
//   The block returns one result per request on the output channel
//   (out_valid_o / out_ready_i / out_req_o) holding the UTC+8 date and time.
//   Path: an accepted request is held in the input register, then moves into
//   the result register once the result slot is free or being drained by the
//   receiver, and is shown from there.
//   Throughput: one request per cycle while the receiver takes every result;
//   the whole conversion is one combinational pass between the two registers.
//   Stall: while a result waits the input register still takes one more
//   request; only when both are full does in_ready_o drop. Results come out
//   in request order and are held unchanged until taken.
//   Reset: rst_ni low empties both registers at once; nothing else is kept.
`default_nettype none

module timezone_shift_to_utc_plus8 (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   in_valid_i,
  output logic                  in_ready_o,
  input  wire tzs_pkg::tz_req_t in_req_i,
  output logic                  out_valid_o,
  input  wire                   out_ready_i,
  output tzs_pkg::tz_res_t      out_req_o
);

  logic             s0_valid_q, s0_valid_d;
  tzs_pkg::tz_req_t s0_req_q;
  logic             out_valid_q, out_valid_d;
  tzs_pkg::tz_res_t out_res_q;
  tzs_pkg::tz_res_t conv_res;
  logic             advance;

  // Move the held request forward whenever the result slot is free or draining
  assign advance    = s0_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s0_valid_q || advance;

  always_comb begin
    s0_valid_d = s0_valid_q;
    if (in_valid_i && in_ready_o) begin
      s0_valid_d = 1'b1;
    end else if (advance) begin
      s0_valid_d = 1'b0;
    end

    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  tzs_convert u_convert (
    .req_i (s0_req_q),
    .res_o (conv_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s0_valid_q  <= s0_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers: capture on handshake, hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      s0_req_q <= in_req_i;
    end
    if (advance) begin
      out_res_q <= conv_res;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_res_q;

endmodule

`default_nettype wire

// ----- rtl/core/tzs_checker.sv -----
// Port-level checks for the UTC+8 time-zone shift block, with its bind.
// Depends on tzs_pkg and the top-level module timezone_shift_to_utc_plus8.
`default_nettype none

module tzs_checker (
  input wire                   clk_i,
  input wire                   rst_ni,
  input wire                   in_ready_o,
  input wire                   out_valid_o,
  input wire                   out_ready_i,
  input wire tzs_pkg::tz_res_t out_req_o
);

  // A stalled result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_req_o))
    else $error("result changed or dropped while stalled");

  // Time of day is always normalised
  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.hour_out < 5'd24) && (out_req_o.minute_out < 6'd60))
    else $error("hour or minute out of range");

  // The year never leaves the 128-year input span widened by the day shift
  a_year_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_req_o.year_out >= 12'd1998) && (out_req_o.year_out <= 12'd2128))
    else $error("year out of range");

  // With the result slot empty the block must take a request
  a_ready_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty result slot");

endmodule

bind timezone_shift_to_utc_plus8 tzs_checker u_tzs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_req_o   (out_req_o)
);

`default_nettype wire
